### src/alrbd_pkg.sv
// Shared types and constants for the ALR budget detector.
package alrbd_pkg;

    // Field widths
    localparam int RATE_W    = 20;
    localparam int TIME_W    = 48;
    localparam int BYTES_W   = 20;
    localparam int LEVEL_W   = 31;
    localparam int RATIO_W   = 17;
    localparam int WINDOW_W  = 14;
    localparam int ELAPSED_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;

    // Shared multiplier: 31 x 24 bits
    localparam int MUL_A_W = 31;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_USAGE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP   = 3'd3;

    // Configuration reset values
    localparam logic [RATIO_W-1:0]  USAGE_RST  = 17'd42598;
    localparam logic [WINDOW_W-1:0] WINDOW_RST = 14'd500;
    localparam logic [RATIO_W-1:0]  START_RST  = 17'd52429;
    localparam logic [RATIO_W-1:0]  STOP_RST   = 17'd32768;

    // Input opcodes
    localparam logic OP_RATE = 1'b0;
    localparam logic OP_SEND = 1'b1;

    typedef struct packed {
        logic [RATIO_W-1:0]  usage;
        logic [WINDOW_W-1:0] window;
        logic [RATIO_W-1:0]  start;
        logic [RATIO_W-1:0]  stop;
    } cfg_regs_t;

    // Datapath micro-operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_MUL_RATE,
        DP_MUL_WIN,
        DP_SET_MAX,
        DP_TIME,
        DP_MUL_ACC,
        DP_SET_LEVEL,
        DP_MUL_RATIO,
        DP_SET_FLAG,
        DP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_send;
        logic rate_zero;
        logic max_zero;
    } dp_status_t;

endpackage

### src/alrbd_ctrl.sv
// Controller state machine: sequences the datapath for one transaction at a time.
module alrbd_ctrl
    import alrbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_MUL_WIN,
        S_SET_MAX,
        S_MUL_ACC,
        S_SET_LEVEL,
        S_MUL_RATIO,
        S_SET_FLAG,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state, commands and output valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = DP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LATCH;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (!status.is_send && !status.rate_zero)
                begin
                    cmd.op     = DP_MUL_RATE;
                    state_next = S_MUL_WIN;
                end
                else if (status.is_send && !status.max_zero)
                begin
                    cmd.op     = DP_TIME;
                    state_next = S_MUL_ACC;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MUL_WIN:
            begin
                cmd.op     = DP_MUL_WIN;
                state_next = S_SET_MAX;
            end
            S_SET_MAX:
            begin
                cmd.op     = DP_SET_MAX;
                state_next = S_DONE;
            end
            S_MUL_ACC:
            begin
                cmd.op     = DP_MUL_ACC;
                state_next = S_SET_LEVEL;
            end
            S_SET_LEVEL:
            begin
                cmd.op     = DP_SET_LEVEL;
                state_next = S_MUL_RATIO;
            end
            S_MUL_RATIO:
            begin
                cmd.op     = DP_MUL_RATIO;
                state_next = S_SET_FLAG;
            end
            S_SET_FLAG:
            begin
                cmd.op     = DP_SET_FLAG;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = DP_LOAD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### src/alrbd_dp.sv
// Datapath: budget state, shared multiplier, clamping and hysteresis compare.
module alrbd_dp
    import alrbd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  cfg_regs_t          cfg,
    input  logic               op,
    input  logic [RATE_W-1:0]  rate_kbps,
    input  logic [TIME_W-1:0]  stamp_ms,
    input  logic [BYTES_W-1:0] byte_count,
    output logic               in_alr,
    output logic [LEVEL_W-1:0] budget_level
);

    // Architectural state
    logic [RATE_W-1:0]  target_reg, target_next;
    logic [LEVEL_W-1:0] max_reg, max_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [TIME_W-1:0]  last_time_reg, last_time_next;
    logic               time_seen_reg, time_seen_next;
    logic               flag_reg, flag_next;

    // Transaction payload and intermediate values
    logic               op_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               out_alr_reg;
    logic [LEVEL_W-1:0] out_level_reg;

    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [PROD_W-1:0]    prod_next;
    logic [RATE_W-1:0]    target_sat;
    logic [LEVEL_W-1:0]   new_max;
    logic [TIME_W-1:0]    time_diff;
    logic [ELAPSED_W-1:0] elapsed_calc;
    logic signed [42:0]   lvl_wide;
    logic [LEVEL_W-1:0]   lvl_clamped;
    logic [47:0]          level_scaled;

    assign status.is_send   = (op_reg == OP_SEND);
    assign status.rate_zero = (rate_reg == '0);
    assign status.max_zero  = (max_reg == '0);

    // Target from rate*usage, saturated to 20 bits
    assign target_sat = (prod_reg[PROD_W-1:36] != '0) ? '1 : prod_reg[35:16];
    // Ceiling from target*window/8
    assign new_max = prod_reg[33:3];

    // Elapsed time: zero before the first send or when time goes back
    assign time_diff = time_reg - last_time_reg;
    always_comb
    begin
        if (!time_seen_reg || !(time_reg > last_time_reg))
            elapsed_calc = '0;
        else if (time_diff[TIME_W-1:ELAPSED_W] != '0)
            elapsed_calc = '1;
        else
            elapsed_calc = time_diff[ELAPSED_W-1:0];
    end

    // Level drain and refill, clamped to 0..max
    assign lvl_wide = $signed({12'b0, level_reg}) - $signed({23'b0, bytes_reg})
                    + $signed({2'b0, prod_reg[43:3]});
    always_comb
    begin
        if (lvl_wide[42])
            lvl_clamped = '0;
        else if (lvl_wide[41:0] > {11'b0, max_reg})
            lvl_clamped = max_reg;
        else
            lvl_clamped = lvl_wide[LEVEL_W-1:0];
    end

    assign level_scaled = {1'b0, level_reg, 16'b0};

    // Shared multiplier operand select
    always_comb
    begin
        case (cmd.op)
            DP_MUL_RATE:
            begin
                mul_a = {11'b0, rate_reg};
                mul_b = {7'b0, cfg.usage};
            end
            DP_MUL_WIN:
            begin
                mul_a = {11'b0, target_sat};
                mul_b = {10'b0, cfg.window};
            end
            DP_MUL_ACC:
            begin
                mul_a = {11'b0, target_reg};
                mul_b = elapsed_reg;
            end
            DP_MUL_RATIO:
            begin
                mul_a = max_reg;
                mul_b = flag_reg ? {7'b0, cfg.stop} : {7'b0, cfg.start};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // State updates per micro-operation
    always_comb
    begin
        target_next    = target_reg;
        max_next       = max_reg;
        level_next     = level_reg;
        last_time_next = last_time_reg;
        time_seen_next = time_seen_reg;
        flag_next      = flag_reg;
        case (cmd.op)
            DP_MUL_WIN:
            begin
                target_next = target_sat;
            end
            DP_SET_MAX:
            begin
                max_next   = new_max;
                level_next = (level_reg > new_max) ? new_max : level_reg;
            end
            DP_TIME:
            begin
                last_time_next = time_reg;
                time_seen_next = 1'b1;
            end
            DP_SET_LEVEL:
            begin
                level_next = lvl_clamped;
            end
            DP_SET_FLAG:
            begin
                // hysteresis: enter above start, leave below stop
                if (!flag_reg && (level_scaled > prod_reg[47:0]))
                    flag_next = 1'b1;
                else if (flag_reg && (level_scaled < prod_reg[47:0]))
                    flag_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            max_reg       <= '0;
            level_reg     <= '0;
            last_time_reg <= '0;
            time_seen_reg <= 1'b0;
            flag_reg      <= 1'b0;
        end
        else
        begin
            target_reg    <= target_next;
            max_reg       <= max_next;
            level_reg     <= level_next;
            last_time_reg <= last_time_next;
            time_seen_reg <= time_seen_next;
            flag_reg      <= flag_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LATCH)
        begin
            op_reg    <= op;
            rate_reg  <= rate_kbps;
            time_reg  <= stamp_ms;
            bytes_reg <= byte_count;
        end
        if (cmd.op == DP_TIME)
            elapsed_reg <= elapsed_calc;
        if (cmd.op == DP_MUL_RATE || cmd.op == DP_MUL_WIN ||
            cmd.op == DP_MUL_ACC || cmd.op == DP_MUL_RATIO)
            prod_reg <= prod_next;
        if (cmd.op == DP_LOAD_OUT)
        begin
            out_alr_reg   <= flag_reg;
            out_level_reg <= level_reg;
        end
    end

    assign in_alr       = out_alr_reg;
    assign budget_level = out_level_reg;

endmodule

### src/alr_budget_detector_core.sv
// Top level of the ALR budget detector: configuration registers, controller, datapath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid / in_stall    | op, rate_kbps, stamp_ms, byte_count
//  output   | out_valid / out_stall  | in_alr, budget_level
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One transaction at a time. Bitrate item: rate multiply, window multiply, ceiling set. Send
// item: time, accrual multiply, level, ratio multiply, flag. Ignored item (zero rate, or send
// with no ceiling): to the result. All share one 31x24 multiplier, at most one use per step.
// Every transaction gives one result; the output register holds it while out_stall
// is high and the next transaction may already be accepted and worked on.
// Reset (rst_n low, asynchronous) clears the budget state and loads register defaults.
module alr_budget_detector_core
    import alrbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  logic [RATE_W-1:0]    rate_kbps,
    input  logic [TIME_W-1:0]    stamp_ms,
    input  logic [BYTES_W-1:0]   byte_count,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 in_alr,
    output logic [LEVEL_W-1:0]   budget_level,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_regs_t  cfg_reg;
    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.usage  <= USAGE_RST;
            cfg_reg.window <= WINDOW_RST;
            cfg_reg.start  <= START_RST;
            cfg_reg.stop   <= STOP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_USAGE:  cfg_reg.usage  <= cfg_data;
                CFG_WINDOW: cfg_reg.window <= cfg_data[WINDOW_W-1:0];
                CFG_START:  cfg_reg.start  <= cfg_data;
                CFG_STOP:   cfg_reg.stop   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    alrbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    alrbd_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg          (cfg_reg),
        .op           (op),
        .rate_kbps    (rate_kbps),
        .stamp_ms     (stamp_ms),
        .byte_count   (byte_count),
        .in_alr       (in_alr),
        .budget_level (budget_level)
    );

    // An accepted transaction keeps the input side busy while it is processed
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted again right after a transaction");

    // A result is only produced at the end of a transaction's processing
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a transaction in progress");

    // The datapath is only commanded to latch input when a transaction is accepted
    a_latch_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_LATCH) |-> (in_valid && !in_stall))
        else $error("input latched without an accepted transaction");

endmodule

### tb/testbench.sv
// Self-checking testbench for the ALR budget detector core.
`timescale 1ns / 1ps

module testbench;
    import alrbd_pkg::*;

    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  DRAIN_CYCLES   = 20;
    localparam int  PHASE_ITEMS    = 317;
    localparam int  NUM_PHASES     = 6;
    localparam int  DIR_ROWS       = 36;
    localparam longint unsigned BITS_PER_BYTE = 8;
    localparam longint unsigned TARGET_SAT    = (64'd1 << RATE_W) - 1;
    localparam longint unsigned ELAPSED_SAT   = (64'd1 << ELAPSED_W) - 1;
    localparam logic [TIME_W-1:0]    TIME_TOP   = '1;
    localparam logic [BYTES_W-1:0]   BYTES_TOP  = '1;
    localparam logic [RATE_W-1:0]    RATE_TOP   = '1;
    localparam logic [CFG_DAT_W-1:0] DATA_TOP   = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_LO = CFG_STOP + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_HI = '1;
    localparam logic [CFG_DAT_W-1:0] Q16_ONE    = 17'd65536;

    typedef struct packed {
        logic               alr;
        logic [LEVEL_W-1:0] level;
    } budget_res_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic                op;
        logic [RATE_W-1:0]   rate;
        logic [TIME_W-1:0]   now;
        logic [BYTES_W-1:0]  bytes;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] val;
        bit                  typed;
        budget_res_t         res;
    } stim_row_t;

    // DUT signals
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 op = OP_RATE;
    logic [RATE_W-1:0]    rate_kbps = '0;
    logic [TIME_W-1:0]    stamp_ms = '0;
    logic [BYTES_W-1:0]   byte_count = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 in_alr;
    logic [LEVEL_W-1:0]   budget_level;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_USAGE;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    // Predictor copy of configuration and budget state
    logic [RATIO_W-1:0]  m_usage  = USAGE_RST;
    logic [WINDOW_W-1:0] m_window = WINDOW_RST;
    logic [RATIO_W-1:0]  m_start  = START_RST;
    logic [RATIO_W-1:0]  m_stop   = STOP_RST;
    logic [RATE_W-1:0]   m_target = '0;
    logic [LEVEL_W-1:0]  m_ceiling = '0;
    logic [LEVEL_W-1:0]  m_level  = '0;
    logic [TIME_W-1:0]   m_last   = '0;
    logic                m_seen   = 1'b0;
    logic                m_alr    = 1'b0;

    budget_res_t pending_res[$];
    int          err_count   = 0;
    int          idle_cycles = 0;
    int          snd_idle_pct = 10;
    int          rcv_idle_pct = 70;

    alr_budget_detector_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .rate_kbps    (rate_kbps),
        .stamp_ms     (stamp_ms),
        .byte_count   (byte_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .in_alr       (in_alr),
        .budget_level (budget_level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Budget predictor: advances the state for one accepted transaction
    function automatic budget_res_t budget_step(input logic op_i,
                                                input logic [RATE_W-1:0] rate_i,
                                                input logic [TIME_W-1:0] now_i,
                                                input logic [BYTES_W-1:0] bytes_i,
                                                output bit skipped);
        longint unsigned prod;
        longint unsigned elapsed;
        longint unsigned scaled;
        longint          lvl;
        budget_res_t     res;
        skipped = 1'b0;
        if (op_i == OP_RATE)
        begin
            if (rate_i == '0)
            begin
                skipped = 1'b1;
            end
            else
            begin
                prod = (64'(rate_i) * 64'(m_usage)) >> 16;
                if (prod > TARGET_SAT)
                    prod = TARGET_SAT;
                m_target  = prod[RATE_W-1:0];
                m_ceiling = LEVEL_W'((64'(m_target) * 64'(m_window)) / BITS_PER_BYTE);
                if (m_level > m_ceiling)
                    m_level = m_ceiling;
            end
        end
        else if (m_ceiling == '0)
        begin
            skipped = 1'b1;
        end
        else
        begin
            // first send seeds the time base
            if (!m_seen)
            begin
                m_last = now_i;
                m_seen = 1'b1;
            end
            elapsed = (now_i > m_last) ? 64'(now_i - m_last) : 64'd0;
            if (elapsed > ELAPSED_SAT)
                elapsed = ELAPSED_SAT;
            m_last = now_i;

            lvl = longint'(64'(m_level)) - longint'(64'(bytes_i))
                + longint'((64'(m_target) * elapsed) / BITS_PER_BYTE);
            if (lvl < 0)
                m_level = '0;
            else if (lvl > longint'(64'(m_ceiling)))
                m_level = m_ceiling;
            else
                m_level = LEVEL_W'(lvl);

            // hysteresis on the fill fraction
            scaled = 64'(m_level) << 16;
            if (!m_alr && scaled > 64'(m_start) * 64'(m_ceiling))
                m_alr = 1'b1;
            else if (m_alr && scaled < 64'(m_stop) * 64'(m_ceiling))
                m_alr = 1'b0;
        end
        res.alr   = m_alr;
        res.level = m_level;
        return res;
    endfunction

    // Register write, only issued once every pending result is out
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_USAGE:  m_usage  = val[RATIO_W-1:0];
            CFG_WINDOW: m_window = val[WINDOW_W-1:0];
            CFG_START:  m_start  = val[RATIO_W-1:0];
            CFG_STOP:   m_stop   = val[RATIO_W-1:0];
            default: ;
        endcase
    endtask

    // One input transaction, with a random sender gap in front of it
    task automatic drive_item(input logic op_i, input logic [RATE_W-1:0] rate_i,
                              input logic [TIME_W-1:0] now_i, input logic [BYTES_W-1:0] bytes_i,
                              input bit typed, input budget_res_t typed_res,
                              output bit skipped);
        budget_res_t res;
        if (cfg_valid)
            cfg_valid <= 1'b0;
        if ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < snd_idle_pct)
                @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= op_i;
        rate_kbps  <= rate_i;
        stamp_ms   <= now_i;
        byte_count <= bytes_i;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = budget_step(op_i, rate_i, now_i, bytes_i, skipped);
        pending_res.push_back(typed ? typed_res : res);
    endtask

    function automatic stim_row_t item_row(input logic op_i, input logic [RATE_W-1:0] rate_i,
                                           input logic [TIME_W-1:0] now_i,
                                           input logic [BYTES_W-1:0] bytes_i);
        stim_row_t r;
        r.kind  = ROW_ITEM;
        r.op    = op_i;
        r.rate  = rate_i;
        r.now   = now_i;
        r.bytes = bytes_i;
        r.idx   = CFG_USAGE;
        r.val   = '0;
        r.typed = 1'b0;
        r.res   = '0;
        return r;
    endfunction

    function automatic stim_row_t known_row(input logic op_i, input logic [RATE_W-1:0] rate_i,
                                            input logic [TIME_W-1:0] now_i,
                                            input logic [BYTES_W-1:0] bytes_i,
                                            input logic alr_i, input logic [LEVEL_W-1:0] level_i);
        stim_row_t r;
        r           = item_row(op_i, rate_i, now_i, bytes_i);
        r.typed     = 1'b1;
        r.res.alr   = alr_i;
        r.res.level = level_i;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx_i,
                                          input logic [CFG_DAT_W-1:0] val_i);
        stim_row_t r;
        r       = item_row(OP_RATE, '0, '0, '0);
        r.kind  = ROW_CFG;
        r.idx   = idx_i;
        r.val   = val_i;
        return r;
    endfunction

    // unused register index, chosen at random
    function automatic logic [CFG_IDX_W-1:0] CFG_INDEX_PICK();
        return CFG_IDX_W'($urandom_range(int'(CFG_NONE_LO), int'(CFG_NONE_HI)));
    endfunction

    // Result checker and receiver stall
    always @(posedge clk)
    begin
        budget_res_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_res.size() == 0)
            begin
                $display("%0t: unexpected result: in_alr %0d, budget_level %0d",
                         $time, in_alr, budget_level);
                err_count++;
            end
            else
            begin
                exp_res = pending_res.pop_front();
                if (in_alr !== exp_res.alr)
                begin
                    $display("%0t: in_alr mismatch: expected %0d, actual %0d",
                             $time, exp_res.alr, in_alr);
                    err_count++;
                end
                if (budget_level !== exp_res.level)
                begin
                    $display("%0t: budget_level mismatch: expected %0d, actual %0d",
                             $time, exp_res.level, budget_level);
                    err_count++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    // Watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus
    initial
    begin
        stim_row_t        dir_rows [DIR_ROWS];
        budget_res_t      no_res;
        bit               skipped;
        int               done;
        logic             nop;
        logic [RATE_W-1:0]    nrate;
        logic [TIME_W-1:0]    stim_ms;
        logic [BYTES_W-1:0]   nbytes;
        logic [CFG_DAT_W-1:0] u_val, w_val, s_val, p_val;
        longint unsigned  accrual;
        longint unsigned  span;
        int unsigned      elapsed;
        int unsigned      pick;

        no_res = '0;
        dir_rows = '{
            // after reset: nothing set yet
            known_row(OP_SEND, '0, 48'd100, 20'd5, 1'b0, '0),
            known_row(OP_RATE, '0, '0, '0, 1'b0, '0),
            known_row(OP_SEND, '0, TIME_TOP, BYTES_TOP, 1'b0, '0),
            // ceiling set, first send seeds time, fill, time going back, drain
            item_row(OP_RATE, 20'd1000, '0, '0),
            item_row(OP_SEND, '0, 48'd1000, 20'd0),
            item_row(OP_SEND, '0, 48'd1100, 20'd100),
            item_row(OP_SEND, '0, 48'd5000, 20'd0),
            item_row(OP_SEND, '0, 48'd4000, 20'd1000),
            item_row(OP_RATE, '0, '0, '0),
            item_row(OP_SEND, '0, 48'd4000, BYTES_TOP),
            // long gap saturates elapsed, then time back to zero
            item_row(OP_SEND, '0, TIME_TOP, 20'd0),
            item_row(OP_SEND, '0, 48'd0, 20'd0),
            item_row(OP_RATE, RATE_TOP, '0, '0),
            item_row(OP_SEND, '0, 48'd30, 20'd0),
            // usage above one: target saturates
            cfg_row(CFG_USAGE, DATA_TOP),
            item_row(OP_RATE, RATE_TOP, '0, '0),
            item_row(OP_SEND, '0, 48'd60, 20'd12345),
            // window wider than its field is masked
            cfg_row(CFG_WINDOW, DATA_TOP),
            item_row(OP_RATE, RATE_TOP, '0, '0),
            item_row(OP_SEND, '0, 48'd100000, BYTES_TOP),
            item_row(OP_SEND, '0, 48'd101000, 20'd0),
            // zero window: ceiling drops to zero, sends ignored
            cfg_row(CFG_WINDOW, '0),
            item_row(OP_RATE, 20'd5000, '0, '0),
            item_row(OP_SEND, '0, 48'd200000, 20'd7),
            cfg_row(CFG_NONE_HI, DATA_TOP),
            cfg_row(CFG_USAGE, '0),
            cfg_row(CFG_WINDOW, 17'd1),
            item_row(OP_RATE, 20'd777, '0, '0),
            // unit usage, enter at any fill, leave below full
            cfg_row(CFG_USAGE, Q16_ONE),
            cfg_row(CFG_START, '0),
            cfg_row(CFG_STOP, Q16_ONE),
            item_row(OP_RATE, 20'd800000, '0, '0),
            item_row(OP_SEND, '0, 48'd200010, 20'd0),
            item_row(OP_SEND, '0, 48'd200011, 20'd0),
            item_row(OP_SEND, '0, 48'd200011, 20'd1),
            item_row(OP_RATE, 20'd1, '0, '0)
        };

        // reset
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            else
                drive_item(dir_rows[i].op, dir_rows[i].rate, dir_rows[i].now,
                           dir_rows[i].bytes, dir_rows[i].typed, dir_rows[i].res, skipped);
        end

        // random phases, each with its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    u_val = USAGE_RST;
                    w_val = CFG_DAT_W'(WINDOW_RST);
                    s_val = START_RST;
                    p_val = STOP_RST;
                end
                1:
                begin
                    u_val = Q16_ONE; w_val = 17'd10000; s_val = Q16_ONE; p_val = '0;
                end
                2:
                begin
                    u_val = DATA_TOP; w_val = 17'd1; s_val = '0; p_val = Q16_ONE;
                end
                default:
                begin
                    u_val = CFG_DAT_W'($urandom_range(2000, 131071));
                    w_val = CFG_DAT_W'($urandom_range(1, 16383));
                    s_val = CFG_DAT_W'($urandom_range(0, 65536));
                    p_val = CFG_DAT_W'($urandom_range(0, s_val));
                end
            endcase
            snd_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 70 : 0;
            rcv_idle_pct = (ph < 2) ? 70 : (ph < 4) ? 10 : 0;

            write_reg(CFG_USAGE, u_val);
            write_reg(CFG_WINDOW, w_val);
            write_reg(CFG_START, s_val);
            write_reg(CFG_STOP, p_val);
            if (ph == 0)
                write_reg(CFG_INDEX_PICK(), CFG_DAT_W'($urandom));

            stim_ms = {16'($urandom), 32'($urandom)};
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                pick   = $urandom_range(0, 99);
                nop    = OP_SEND;
                nrate  = '0;
                nbytes = '0;
                if (m_ceiling == '0 || pick < 8)
                begin
                    // new rate estimate, mostly usable
                    nop = OP_RATE;
                    case ($urandom_range(0, 3))
                        0:       nrate = RATE_W'($urandom_range(1, 2000));
                        3:       nrate = RATE_W'($urandom);
                        default: nrate = RATE_W'($urandom_range(1, 1048575));
                    endcase
                    if (m_ceiling == '0 && nrate < 20'd4096)
                        nrate = RATE_W'($urandom_range(4096, 1048575));
                end
                else if (pick < 10)
                begin
                    nop = OP_RATE;
                end
                else if (pick < 12)
                begin
                    // time jumps anywhere, often backward
                    stim_ms = {16'($urandom), 32'($urandom)};
                    nbytes  = BYTES_W'($urandom);
                end
                else
                begin
                    elapsed = $urandom_range(0, 40);
                    stim_ms = stim_ms + TIME_W'(elapsed);
                    accrual = (64'(m_target) * 64'(elapsed)) / BITS_PER_BYTE;
                    span    = 2 * accrual + 64'(m_ceiling) / 16;
                    if (span > 64'(BYTES_TOP))
                        span = 64'(BYTES_TOP);
                    if ($urandom_range(0, 99) < 5)
                        nbytes = BYTES_W'($urandom);
                    else
                        nbytes = BYTES_W'($urandom_range(0, int'(span)));
                end
                drive_item(nop, nrate, stim_ms, nbytes, 1'b0, no_res, skipped);
                if (!skipped)
                    done++;
            end
        end

        // drain
        in_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### alr_budget_detector_core.f
src/alrbd_pkg.sv
src/alrbd_ctrl.sv
src/alrbd_dp.sv
src/alr_budget_detector_core.sv
tb/testbench.sv
